### rtl/olx_pkg.sv
// ----------------------------------------------------------------------------
// olx_pkg - shared types and constants for the outline extractor
// Image geometry, row storage type and the row job passed front to back.
// ----------------------------------------------------------------------------
package olx_pkg;

  localparam int IMAGE_WIDTH  = 64;
  localparam int IMAGE_HEIGHT = 64;
  localparam int ROW_BYTES    = (IMAGE_WIDTH + 7) / 8;
  localparam int COL_W        = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W        = $clog2(IMAGE_HEIGHT);
  localparam int JOB_DEPTH    = 2;

  // byte 0 is the leftmost byte of the row
  typedef logic [ROW_BYTES-1:0][7:0] row_t;

  typedef enum logic [1:0] {
    JOB_FIRST = 2'd0,  // top row, sent raw
    JOB_INNER = 2'd1,  // interior row, outlined
    JOB_LAST  = 2'd2   // last interior row outlined, then bottom row raw
  } job_mode_e;

  typedef struct packed {
    job_mode_e mode;
    row_t      above;
    row_t      centre;
    row_t      below;
  } row_job_t;

endpackage

### rtl/olx_front.sv
// ----------------------------------------------------------------------------
// olx_front - input side of the outline extractor
// Collects bytes into the row buffers; hands a job on at row ends after row 0.
// ----------------------------------------------------------------------------
module olx_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        pixel_byte_i,
  output logic              job_push_o,
  output olx_pkg::row_job_t job_o,
  input  logic              job_full_i
);
  import olx_pkg::*;

  row_t             above_q, above_d;
  row_t             centre_q, centre_d;
  row_t             filling_q, filling_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             row_end, img_end, accept;

  assign row_end = (col_q == COL_W'(ROW_BYTES - 1));
  assign img_end = row_end && (row_q == ROW_W'(IMAGE_HEIGHT - 1));
  // only the row-closing item needs room in the job queue
  assign full    = row_end && (row_q != '0) && job_full_i;
  assign accept  = push && !full;

  always_comb begin
    filling_d          = filling_q;
    filling_d[col_q]   = pixel_byte_i;
    above_d            = above_q;
    centre_d           = centre_q;
    col_d              = col_q;
    row_d              = row_q;
    job_push_o         = 1'b0;
    job_o.mode         = img_end ? JOB_LAST : ((row_q == ROW_W'(1)) ? JOB_FIRST : JOB_INNER);
    job_o.above        = above_q;
    job_o.centre       = centre_q;
    job_o.below        = filling_d;
    if (accept) begin
      if (row_end) begin
        col_d      = '0;
        row_d      = img_end ? '0 : row_q + ROW_W'(1);
        above_d    = centre_q;
        centre_d   = filling_d;
        job_push_o = (row_q != '0);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // row contents: payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      filling_q <= filling_d;
      above_q   <= above_d;
      centre_q  <= centre_d;
    end
  end

endmodule

### rtl/olx_job_fifo.sv
// ----------------------------------------------------------------------------
// olx_job_fifo - short queue of row jobs
// Two entries between the front and the back.
// ----------------------------------------------------------------------------
module olx_job_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  olx_pkg::row_job_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output olx_pkg::row_job_t rd_data_o,
  output logic              empty_o
);
  import olx_pkg::*;

  localparam int PTR_W = $clog2(JOB_DEPTH);

  row_job_t           mem_q [JOB_DEPTH];
  logic [PTR_W-1:0]   wp_q, rp_q;
  logic [PTR_W:0]     cnt_q;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == (PTR_W+1)'(JOB_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
      if (do_rd) rp_q <= (rp_q == PTR_W'(JOB_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
      if (do_wr && !do_rd)      cnt_q <= cnt_q + (PTR_W+1)'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

### rtl/olx_back.sv
// ----------------------------------------------------------------------------
// olx_back - output side of the outline extractor
// Walks a row job byte by byte, applies the 4-neighbour rule, drives results.
// ----------------------------------------------------------------------------
module olx_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  olx_pkg::row_job_t job_i,
  input  logic              job_empty_i,
  output logic              job_pop_o,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        outline_byte_o,
  output logic              image_end_o
);
  import olx_pkg::*;

  localparam int ROW_BITS = ROW_BYTES * 8;

  logic [COL_W-1:0]    byte_q;
  logic                half_q;       // second half of a last-row job
  logic                out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_end_q;

  logic [ROW_BITS-1:0] abv_c, cen_c, blw_c;  // bit c is column c
  row_t                kill_row;
  logic                step, job_done;
  logic [7:0]          byte_val;
  logic                byte_end;

  always_comb begin
    for (int c = 0; c < ROW_BITS; c++) begin
      abv_c[c] = job_i.above[c >> 3][7 - (c & 7)];
      cen_c[c] = job_i.centre[c >> 3][7 - (c & 7)];
      blw_c[c] = job_i.below[c >> 3][7 - (c & 7)];
    end
    kill_row = '0;
    for (int c = 1; c <= IMAGE_WIDTH - 2; c++) begin
      kill_row[c >> 3][7 - (c & 7)] = cen_c[c] & cen_c[c-1] & cen_c[c+1]
                                      & abv_c[c] & blw_c[c];
    end
  end

  always_comb begin
    byte_end = 1'b0;
    case (job_i.mode)
      JOB_FIRST: byte_val = job_i.centre[byte_q];
      JOB_INNER: byte_val = job_i.centre[byte_q] & ~kill_row[byte_q];
      JOB_LAST: begin
        if (half_q) begin
          byte_val = job_i.below[byte_q];
          byte_end = (byte_q == COL_W'(ROW_BYTES - 1));
        end else begin
          byte_val = job_i.centre[byte_q] & ~kill_row[byte_q];
        end
      end
      default:   byte_val = job_i.centre[byte_q];
    endcase
  end

  assign step      = !job_empty_i && (!out_valid_q || pop);
  assign job_done  = (byte_q == COL_W'(ROW_BYTES - 1))
                     && (half_q || (job_i.mode != JOB_LAST));
  assign job_pop_o = step && job_done;

  assign empty          = !out_valid_q;
  assign outline_byte_o = out_byte_q;
  assign image_end_o    = out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q      <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        if (byte_q == COL_W'(ROW_BYTES - 1)) begin
          byte_q <= '0;
          half_q <= !job_done;
        end else begin
          byte_q <= byte_q + COL_W'(1);
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_byte_q <= byte_val;
      out_end_q  <= byte_end;
    end
  end

endmodule

### rtl/binary_image_outline_extract.sv
// ----------------------------------------------------------------------------
// binary_image_outline_extract - 4-neighbour outline of a packed 1-bit image
// Clears set pixels whose four direct neighbours are set; border passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): one item is one byte of eight pixels, MSB is
//   the leftmost pixel, rows in order, ROW_BYTES items per row. One item can
//   be taken every cycle while full is low. full rises only on the item that
//   closes a row when both row jobs in the job queue are still pending.
//   Result channel (empty/pop): one item is one outlined byte; image_end_o
//   marks the last byte of the image. Results leave at one per cycle while
//   pop is held and a row job is queued. The bytes of row r follow the
//   item that closes row r+1, through the job queue write and then the
//   output register. The last input item queues both the last interior row
//   and the bottom row, 2*ROW_BYTES results. Throughput: one item per cycle
//   sustained while the receiver pops; the back drains ROW_BYTES results per
//   ROW_BYTES input items, and a row of slack sits in the two-entry job queue.
//   Receiver stall: the output register holds; the back stops, the queue
//   fills, then full holds off the front at its next row end.
//   Reset: row and byte counters clear, queue and output register empty;
//   the first item after reset starts a new image.
// ----------------------------------------------------------------------------
module binary_image_outline_extract (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] outline_byte_o,
  output logic       image_end_o
);
  import olx_pkg::*;

  row_job_t job_wr, job_rd;
  logic     job_push, job_full, job_pop, job_empty;

  // front: row buffers and row/byte counters
  olx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .pixel_byte_i (pixel_byte_i),
    .job_push_o   (job_push),
    .job_o        (job_wr),
    .job_full_i   (job_full)
  );

  // decouples row arrival from row drain
  olx_job_fifo u_jobs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_data_i (job_wr),
    .full_o    (job_full),
    .rd_i      (job_pop),
    .rd_data_o (job_rd),
    .empty_o   (job_empty)
  );

  // back: per-byte outline and output register
  olx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (job_rd),
    .job_empty_i    (job_empty),
    .job_pop_o      (job_pop),
    .empty          (empty),
    .pop            (pop),
    .outline_byte_o (outline_byte_o),
    .image_end_o    (image_end_o)
  );

endmodule
